// ----- hw/rtl/scdf_pkg.sv -----
// Shared types and constants for the serial frame deframer.
package scdf_pkg;

  localparam int unsigned POS_W    = 4;
  localparam int unsigned HDR_N    = 5;
  localparam int unsigned HDR_END  = 6;
  localparam int unsigned PAYLD_W  = 64;
  localparam int unsigned OUT_DW   = 104;
  localparam int unsigned CFG_AW   = 2;

  localparam logic [POS_W-1:0] POS_HUNT = 4'd0;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SYNC_BYTE = 2'd0;

  // header byte slots
  localparam int unsigned HDR_FLAGS = 0;
  localparam int unsigned HDR_KIND  = 1;
  localparam int unsigned HDR_CMD   = 2;
  localparam int unsigned HDR_DST   = 3;
  localparam int unsigned HDR_LEN   = 4;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic               frame_status;
    logic [2:0]         priority_res;
    logic               write_flag;
    logic               eeprom_flag;
    logic               remote_flag;
    logic [7:0]         msg_kind;
    logic [7:0]         command;
    logic [7:0]         destination;
    logic [3:0]         payload_length;
    logic [3:0]         interface_id;
    logic [PAYLD_W-1:0] payload;
  } frame_res_t;

  typedef struct packed {
    logic done;     // checksum byte taken this cycle, result valid
    logic at_csum;  // next byte is the checksum byte
  } frame_stat_t;

endpackage

// ----- hw/rtl/scdf_frame.sv -----
// Byte position counter, running checksum and field capture for one frame.
module scdf_frame #(
  parameter int unsigned DATA_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_take,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          sync_byte,
  output scdf_pkg::frame_stat_t stat,
  output scdf_pkg::frame_res_t  res
);

  localparam logic [scdf_pkg::POS_W-1:0] CSUM_POS =
    scdf_pkg::POS_W'(scdf_pkg::HDR_END + DATA_BYTES);

  logic [scdf_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic [7:0]                   hdr_r [scdf_pkg::HDR_N];
  logic [scdf_pkg::PAYLD_W-1:0] payload_r, payload_nxt;
  logic                         hunting, at_csum;

  assign hunting = (pos_r == scdf_pkg::POS_HUNT);
  assign at_csum = (pos_r == CSUM_POS);

  always_comb begin
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    payload_nxt = payload_r;
    if (byte_take) begin
      if (hunting) begin
        if (rx_byte == sync_byte) begin
          pos_nxt     = scdf_pkg::POS_W'(1);
          sum_nxt     = rx_byte;
          payload_nxt = '0;  // unused upper lanes must read zero
        end
      end else if (at_csum) begin
        pos_nxt = scdf_pkg::POS_HUNT;
        sum_nxt = '0;
      end else begin
        pos_nxt = pos_r + scdf_pkg::POS_W'(1);
        sum_nxt = sum_r + rx_byte;
        for (int i = 0; i < DATA_BYTES; i++) begin
          if (pos_r == scdf_pkg::POS_W'(scdf_pkg::HDR_END + i)) begin
            payload_nxt[8*i +: 8] = rx_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= scdf_pkg::POS_HUNT;
      sum_r     <= '0;
      payload_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
      payload_r <= payload_nxt;
    end
  end

  // header bytes sit at positions 1..5
  always_ff @(posedge clk) begin
    for (int i = 0; i < scdf_pkg::HDR_N; i++) begin
      if (byte_take && pos_r == scdf_pkg::POS_W'(i + 1)) begin
        hdr_r[i] <= rx_byte;
      end
    end
  end

  assign stat.done    = byte_take && at_csum;
  assign stat.at_csum = at_csum;

  assign res.frame_status   = (rx_byte == sum_r) ? scdf_pkg::STATUS_OK : scdf_pkg::STATUS_BAD;
  assign res.priority_res   = hdr_r[scdf_pkg::HDR_FLAGS][7:5];
  assign res.write_flag     = hdr_r[scdf_pkg::HDR_FLAGS][4];
  assign res.eeprom_flag    = hdr_r[scdf_pkg::HDR_FLAGS][3];
  assign res.remote_flag    = hdr_r[scdf_pkg::HDR_FLAGS][0];
  assign res.msg_kind       = hdr_r[scdf_pkg::HDR_KIND];
  assign res.command        = hdr_r[scdf_pkg::HDR_CMD];
  assign res.destination    = hdr_r[scdf_pkg::HDR_DST];
  assign res.payload_length = hdr_r[scdf_pkg::HDR_LEN][7:4];
  assign res.interface_id   = hdr_r[scdf_pkg::HDR_LEN][3:0];
  assign res.payload        = payload_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CSUM_POS)
    else $error("byte position past checksum slot");

  a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> (pos_r == scdf_pkg::POS_HUNT) && (sum_r == 8'd0))
    else $error("frame end did not return to hunting");

endmodule

// ----- hw/rtl/serial_can_frame_deframer_core.sv -----
// Top level: stream ports, sync byte register and result output register.
// A result appears on out_tvalid in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle, unless the checksum byte is held back as described below.
// Only the checksum byte waits for the output register; other bytes are taken while a
// result is held. Synchronous active-low reset clears the position, running sum,
// sync byte (to zero) and the output valid flag.
module serial_can_frame_deframer_core #(
  parameter int unsigned DATA_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] priority_res, [3] write_flag, [4] eeprom_flag, [5] remote_flag,
  // [13:6] msg_kind, [21:14] command, [29:22] destination, [33:30] payload_length,
  // [37:34] interface_id, [101:38] payload, [103:102] zero
  output logic [scdf_pkg::OUT_DW-1:0]   out_tdata,
  output logic                          out_tuser,  // [0] frame_status
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [scdf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [7:0]             sync_r;
  logic                   out_valid_r;
  scdf_pkg::frame_res_t   out_res_r;
  scdf_pkg::frame_res_t   res;
  scdf_pkg::frame_stat_t  stat;
  logic                   in_take;
  logic                   cfg_wr;

  assign cfg_pready = 1'b1;
  // a single register holding the sync byte, read back zero-extended; cfg_paddr is not decoded
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {24'd0, sync_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= '0;
    end else if (cfg_wr) begin
      sync_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready = !stat.at_csum || !out_valid_r || out_tready;
  assign in_take   = in_tvalid && in_tready;

  scdf_frame #(
    .DATA_BYTES(DATA_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (in_take),
    .rx_byte   (in_tdata),
    .sync_byte (sync_r),
    .stat      (stat),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.frame_status;
  assign out_tdata  = {2'b00,
                       out_res_r.payload,
                       out_res_r.interface_id,
                       out_res_r.payload_length,
                       out_res_r.destination,
                       out_res_r.command,
                       out_res_r.msg_kind,
                       out_res_r.remote_flag,
                       out_res_r.eeprom_flag,
                       out_res_r.write_flag,
                       out_res_r.priority_res};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (!out_valid_r || out_tready))
    else $error("result request overwrote a pending one");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stat.done))
    else $error("output valid without a finished frame");

endmodule
